// ===== sv/ffha_pkg.sv =====
// Shared types and constants of the first-fit heap allocator.
`default_nettype none
package ffha_pkg;
  localparam int DEF_HEAP_BYTES   = 4096;
  localparam int DEF_HEADER_BYTES = 16;
  localparam int REQ_W            = 12;

  typedef enum logic [1:0] {
    OP_NOP,
    OP_ALLOC,
    OP_FREE
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [REQ_W-1:0] req;
    logic [REQ_W-1:0] off;
  } cmd_t;
endpackage
`default_nettype wire

// ===== sv/ffha_if.sv =====
// Request and result channel interfaces of the allocator.
`default_nettype none
interface ffha_in_if;
  logic                       valid;
  logic                       ready;
  logic                       mode;
  logic [ffha_pkg::REQ_W-1:0] request_bytes;
  logic [ffha_pkg::REQ_W-1:0] free_offset;
  modport source(output valid, output mode, output request_bytes, output free_offset,
                 input ready);
  modport sink(input valid, input mode, input request_bytes, input free_offset,
               output ready);
endinterface

interface ffha_out_if;
  logic                       valid;
  logic                       ready;
  logic                       ok;
  logic [ffha_pkg::REQ_W-1:0] payload_offset;
  modport source(output valid, output ok, output payload_offset, input ready);
  modport sink(input valid, input ok, input payload_offset, output ready);
endinterface
`default_nettype wire

// ===== sv/ffha_front.sv =====
// Front end: accepts request beats, classifies them and queues commands.
`default_nettype none
module ffha_front #(
  parameter int HEAP_BYTES   = ffha_pkg::DEF_HEAP_BYTES,
  parameter int HEADER_BYTES = ffha_pkg::DEF_HEADER_BYTES
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  ffha_in_if.sink             in_if,
  output ffha_pkg::cmd_t      cmd_o,
  output logic                cmd_valid_o,
  input  wire logic           cmd_ready_i
);
  import ffha_pkg::*;

  localparam int AW = $clog2(HEAP_BYTES);
  localparam int W  = ((AW > REQ_W) ? AW : REQ_W) + 2;

  cmd_t       q_mem [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  cmd_t       cls;
  logic       push, pop;

  always_comb begin
    cls.req = in_if.request_bytes;
    cls.off = in_if.free_offset;
    if (!in_if.mode) begin
      cls.op = OP_ALLOC;
    end else if (in_if.free_offset != '0 &&
                 W'(in_if.free_offset) >= W'(HEADER_BYTES) &&
                 W'(in_if.free_offset) - W'(HEADER_BYTES) < W'(HEAP_BYTES)) begin
      cls.op = OP_FREE;
    end else begin
      cls.op = OP_NOP;
    end
  end

  assign in_if.ready = (cnt_q != 2'd2);
  assign push        = in_if.valid && in_if.ready;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = q_mem[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) q_mem[wp_q] <= cls;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

// ===== sv/ffha_back.sv =====
// Back end: header memories, block walk engine and result register.
`default_nettype none
module ffha_back #(
  parameter int HEAP_BYTES   = ffha_pkg::DEF_HEAP_BYTES,
  parameter int HEADER_BYTES = ffha_pkg::DEF_HEADER_BYTES
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire ffha_pkg::cmd_t cmd_i,
  input  wire logic           cmd_valid_i,
  output logic                cmd_ready_o,
  ffha_out_if.source          out_if
);
  import ffha_pkg::*;

  localparam int AW = $clog2(HEAP_BYTES);
  localparam int W  = ((AW > REQ_W) ? AW : REQ_W) + 2;
  localparam logic [W-1:0] HW   = W'(HEADER_BYTES);
  localparam logic [W-1:0] HEAP = W'(HEAP_BYTES);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_A_RD, S_A_EV, S_A_WR, S_F_CLR, S_M_RD, S_M_EV0, S_M_EVN, S_FIN
  } state_e;

  logic [AW-1:0] size_mem [HEAP_BYTES];
  logic          used_mem [HEAP_BYTES];

  state_e           state_q;
  logic [AW-1:0]    cur_q, nxt_q, size_c_q;
  logic             used_c_q, split_q;
  logic [REQ_W-1:0] req_q, off_q;
  logic             res_ok_q;
  logic [REQ_W-1:0] res_pay_q;
  logic             out_v_q, out_ok_q;
  logic [REQ_W-1:0] out_pay_q;

  logic [AW-1:0] rd_addr, rd_size_q;
  logic          rd_used_q;
  logic          sz_we, us_we, us_wd;
  logic [AW-1:0] sz_wa, us_wa, sz_wd;

  logic [W-1:0] size_w, left_w, pay_w, rem_w, nxt_w, merged_w, nxt2_w;
  logic         fit, join_n;

  always_comb begin
    size_w   = W'(rd_size_q);
    fit      = !rd_used_q && size_w >= W'(req_q);
    left_w   = size_w - W'(req_q);
    pay_w    = W'(cur_q) + HW;
    rem_w    = pay_w + W'(req_q);
    nxt_w    = W'(cur_q) + HW + size_w;
    join_n   = !used_c_q && !rd_used_q;
    merged_w = W'(size_c_q) + HW + size_w;
    nxt2_w   = join_n ? (W'(cur_q) + HW + merged_w) : (W'(nxt_q) + HW + size_w);
  end

  always_comb begin
    rd_addr = cur_q;
    sz_we = 1'b0; sz_wa = cur_q;
    us_we = 1'b0; us_wa = cur_q; us_wd = 1'b0;
    sz_wd = AW'(req_q);
    case (state_q)
      S_INIT: begin
        sz_we = 1'b1; sz_wa = '0; sz_wd = AW'(HEAP - HW);
        us_we = 1'b1; us_wa = '0;
      end
      S_A_EV: begin
        if (fit && left_w > HW && rem_w < HEAP) begin
          sz_we = 1'b1; sz_wa = rem_w[AW-1:0]; sz_wd = AW'(left_w - HW);
          us_we = 1'b1; us_wa = rem_w[AW-1:0];
        end
      end
      S_A_WR: begin
        sz_we = split_q;
        us_we = 1'b1; us_wd = 1'b1;
      end
      S_F_CLR: begin
        us_we = 1'b1; us_wa = AW'(W'(off_q) - HW);
      end
      S_M_EV0: rd_addr = nxt_w[AW-1:0];
      S_M_EVN: begin
        rd_addr = nxt2_w[AW-1:0];
        if (join_n) begin
          sz_we = 1'b1; sz_wd = merged_w[AW-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (sz_we) size_mem[sz_wa] <= sz_wd;
    if (us_we) used_mem[us_wa] <= us_wd;
    rd_size_q <= size_mem[rd_addr];
    rd_used_q <= used_mem[rd_addr];
  end

  assign cmd_ready_o    = (state_q == S_IDLE);
  assign out_if.valid   = out_v_q;
  assign out_if.ok      = out_ok_q;
  assign out_if.payload_offset = out_pay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_INIT;
      out_v_q  <= 1'b0;
      cur_q    <= '0;
      nxt_q    <= '0;
      size_c_q <= '0;
      used_c_q <= 1'b0;
      split_q  <= 1'b0;
      req_q    <= '0;
      off_q    <= '0;
      res_ok_q <= 1'b0;
      res_pay_q <= '0;
      out_ok_q <= 1'b0;
      out_pay_q <= '0;
    end else begin
      if (out_v_q && out_if.ready && state_q != S_FIN) out_v_q <= 1'b0;
      case (state_q)
        S_INIT: state_q <= S_IDLE;
        S_IDLE: begin
          if (cmd_valid_i) begin
            req_q <= cmd_i.req;
            off_q <= cmd_i.off;
            cur_q <= '0;
            case (cmd_i.op)
              OP_ALLOC: state_q <= S_A_RD;
              OP_FREE:  state_q <= S_F_CLR;
              default: begin
                res_ok_q  <= 1'b1;
                res_pay_q <= '0;
                state_q   <= S_FIN;
              end
            endcase
          end
        end
        S_A_RD: state_q <= S_A_EV;
        S_A_EV: begin
          if (fit) begin
            split_q   <= left_w > HW;
            res_ok_q  <= 1'b1;
            res_pay_q <= REQ_W'(pay_w);
            state_q   <= S_A_WR;
          end else if (nxt_w >= HEAP) begin
            res_ok_q  <= 1'b0;
            res_pay_q <= '0;
            state_q   <= S_FIN;
          end else begin
            cur_q   <= nxt_w[AW-1:0];
            state_q <= S_A_RD;
          end
        end
        S_A_WR: state_q <= S_FIN;
        S_F_CLR: begin
          res_ok_q  <= 1'b1;
          res_pay_q <= '0;
          state_q   <= S_M_RD;
        end
        S_M_RD: state_q <= S_M_EV0;
        S_M_EV0: begin
          size_c_q <= rd_size_q;
          used_c_q <= rd_used_q;
          nxt_q    <= nxt_w[AW-1:0];
          state_q  <= (nxt_w >= HEAP) ? S_FIN : S_M_EVN;
        end
        S_M_EVN: begin
          if (join_n) begin
            size_c_q <= merged_w[AW-1:0];
          end else begin
            cur_q    <= nxt_q;
            size_c_q <= rd_size_q;
            used_c_q <= rd_used_q;
          end
          nxt_q   <= nxt2_w[AW-1:0];
          if (nxt2_w >= HEAP) state_q <= S_FIN;
        end
        S_FIN: begin
          if (!out_v_q || out_if.ready) begin
            out_v_q   <= 1'b1;
            out_ok_q  <= res_ok_q;
            out_pay_q <= res_pay_q;
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== sv/first_fit_heap_allocator_core.sv =====
// Top level of the first-fit heap allocator over an implicit block list.
//   channel  dir  beat
//   in_if    in   mode, request_bytes, free_offset
//   out_if   out  ok, payload_offset
// Allocate: reads and checks each block in turn; a grant then writes the header.
// Free: clears the used bit, then a merge walk over the whole heap; a null free only answers.
// Fewer than HEAP_BYTES/HEADER_BYTES blocks; each takes HEADER_BYTES of header.
// After reset the S_INIT state writes the whole-heap free block before commands run.
// A two-entry command queue lets requests arrive while a walk runs.
// A result beat that is not taken holds the engine until the previous one leaves.
`default_nettype none
module first_fit_heap_allocator_core #(
  parameter int HEAP_BYTES   = ffha_pkg::DEF_HEAP_BYTES,
  parameter int HEADER_BYTES = ffha_pkg::DEF_HEADER_BYTES
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ffha_in_if.sink    in_if,
  ffha_out_if.source out_if
);
  import ffha_pkg::*;

  cmd_t cmd;
  logic cmd_valid, cmd_ready;

  ffha_front #(.HEAP_BYTES(HEAP_BYTES), .HEADER_BYTES(HEADER_BYTES)) u_front (
    .clk_i, .rst_ni, .in_if,
    .cmd_o(cmd), .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready)
  );

  ffha_back #(.HEAP_BYTES(HEAP_BYTES), .HEADER_BYTES(HEADER_BYTES)) u_back (
    .clk_i, .rst_ni,
    .cmd_i(cmd), .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready), .out_if
  );
endmodule
`default_nettype wire

// ===== sim/first_fit_heap_allocator_core_tb.sv =====
// Testbench of the first-fit heap allocator: directed and random allocate/free beats.
module first_fit_heap_allocator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HEAP = ffha_pkg::DEF_HEAP_BYTES;
  localparam int HDR  = ffha_pkg::DEF_HEADER_BYTES;
  localparam int REQ_W = ffha_pkg::REQ_W;
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;
  localparam int CYCLE_LIMIT = 4000000;

  typedef struct packed {
    logic             ok;
    logic [REQ_W-1:0] offset;
  } grant_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #2 clk_i = ~clk_i;

  ffha_in_if  in_if ();
  ffha_out_if out_if ();

  first_fit_heap_allocator_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if.sink),
    .out_if (out_if.source)
  );

  int unsigned blk_len [HEAP];
  bit          blk_busy[HEAP];
  grant_t      pending_grants[$];
  logic [REQ_W-1:0] live_offsets[$];
  int errors = 0;
  int n_alloc = 0, n_free = 0, n_fail = 0;
  int cycles = 0;
  int sink_mode = 0;

  function automatic int unsigned next_hdr(int unsigned pos);
    int unsigned nxt;
    if (pos >= HEAP) return HEAP;
    nxt = pos + HDR + blk_len[pos];
    return (nxt >= HEAP) ? HEAP : nxt;
  endfunction

  function automatic void coalesce();
    int unsigned cur, nxt;
    cur = 0;
    while (cur < HEAP) begin
      nxt = next_hdr(cur);
      if (nxt < HEAP && !blk_busy[cur] && !blk_busy[nxt]) blk_len[cur] += HDR + blk_len[nxt];
      else cur = nxt;
    end
  endfunction

  function automatic grant_t predict_grant(logic mode, logic [REQ_W-1:0] req,
                                           logic [REQ_W-1:0] off);
    grant_t g;
    int unsigned cur, left, pay, h;
    g = '{ok: 1'b1, offset: '0};
    if (mode == MODE_ALLOC) begin
      cur = 0;
      while (cur < HEAP) begin
        if (!blk_busy[cur] && blk_len[cur] >= req) break;
        cur = next_hdr(cur);
      end
      if (cur >= HEAP) begin
        g.ok = 1'b0;
        return g;
      end
      left = blk_len[cur] - req;
      pay = cur + HDR;
      if (left > HDR) begin
        if (pay + req < HEAP) begin
          blk_len[pay + req] = left - HDR;
          blk_busy[pay + req] = 1'b0;
        end
        blk_len[cur] = req;
      end
      blk_busy[cur] = 1'b1;
      g.offset = pay[REQ_W-1:0];
    end else if (off != 0 && off >= HDR) begin
      h = off - HDR;
      if (h < HEAP) begin
        blk_busy[h] = 1'b0;
        coalesce();
      end
    end
    return g;
  endfunction

  task automatic send_beat(logic mode, logic [REQ_W-1:0] req, logic [REQ_W-1:0] off);
    grant_t g;
    if ($urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.mode <= mode;
    in_if.request_bytes <= req;
    in_if.free_offset <= off;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    g = predict_grant(mode, req, off);
    pending_grants.push_back(g);
    if (mode == MODE_ALLOC) begin
      n_alloc++;
      if (g.ok) live_offsets.push_back(g.offset);
      else n_fail++;
    end else n_free++;
    @(negedge clk_i);
  endtask

  task automatic alloc_beat(logic [REQ_W-1:0] req);
    send_beat(MODE_ALLOC, req, REQ_W'($urandom));
  endtask

  task automatic free_beat(logic [REQ_W-1:0] off);
    send_beat(MODE_FREE, REQ_W'($urandom), off);
  endtask

  task automatic free_live_random();
    int i;
    i = $urandom_range(0, live_offsets.size() - 1);
    free_beat(live_offsets[i]);
    live_offsets.delete(i);
  endtask

  always @(posedge clk_i) begin
    grant_t want;
    cycles <= cycles + 1;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_grants.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        want = pending_grants.pop_front();
        if (out_if.ok !== want.ok) begin
          $error("ok: expected %0d actual %0d", want.ok, out_if.ok);
          errors++;
        end
        if (out_if.payload_offset !== want.offset) begin
          $error("payload_offset: expected %0d actual %0d", want.offset,
                 out_if.payload_offset);
          errors++;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    case (sink_mode)
      0: out_if.ready <= 1'b1;
      1: out_if.ready <= ($urandom_range(0, 3) != 0);
      default: out_if.ready <= ($urandom_range(0, 9) < 3);
    endcase
    if ($urandom_range(0, 199) == 0) sink_mode <= $urandom_range(0, 2);
  end

  always @(posedge clk_i) begin
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic test_edges();
    alloc_beat(REQ_W'(0));
    alloc_beat(12'hFFF);
    alloc_beat(REQ_W'(HEAP - 3 * HDR));
    free_beat(REQ_W'(0));
    free_beat(REQ_W'(HDR - 1));
    free_beat(12'h001);
    free_beat(12'hFFF);
    free_beat(REQ_W'(HDR + 8));
    free_beat(REQ_W'(HDR));
    free_beat(REQ_W'(2 * HDR));
    alloc_beat(REQ_W'(HEAP - HDR));
    free_beat(REQ_W'(HDR));
    alloc_beat(REQ_W'(HEAP - 2 * HDR));
    alloc_beat(REQ_W'(1));
    free_beat(REQ_W'(HDR));
    alloc_beat(REQ_W'(HEAP - HDR - HDR));
    free_beat(REQ_W'(HDR));
    alloc_beat(REQ_W'(HEAP - HDR - 1));
    free_beat(REQ_W'(HDR));
  endtask

  task automatic test_random_mix(int count);
    int r;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        if ($urandom_range(0, 9) == 0) alloc_beat(REQ_W'($urandom));
        else alloc_beat(REQ_W'($urandom_range(0, 200)));
      end else if (r < 85 && live_offsets.size() > 0) free_live_random();
      else if (r < 92) free_beat(REQ_W'($urandom));
      else if (r < 96) free_beat(REQ_W'($urandom_range(0, HDR - 1)));
      else alloc_beat(REQ_W'($urandom_range(0, 2) * 12'hFFF / 2));
    end
  endtask

  task automatic test_drain_all();
    while (live_offsets.size() > 0) free_live_random();
    alloc_beat(REQ_W'(HEAP - HDR));
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.mode = MODE_ALLOC;
    in_if.request_bytes = '0;
    in_if.free_offset = '0;
    foreach (blk_len[i]) begin
      blk_len[i] = 0;
      blk_busy[i] = 1'b0;
    end
    blk_len[0] = HEAP - HDR;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    test_edges();
    test_random_mix(1500);
    test_drain_all();
    in_if.valid <= 1'b0;
    while (pending_grants.size() > 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
    $display("covered %0d allocates (%0d out of memory) and %0d frees", n_alloc, n_fail,
             n_free);
    $display("frees included null, below-header, non-block and live offsets");
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

// ===== files.f =====
sv/ffha_pkg.sv
sv/ffha_if.sv
sv/ffha_front.sv
sv/ffha_back.sv
sv/first_fit_heap_allocator_core.sv
sim/first_fit_heap_allocator_core_tb.sv
